[src/iwu_pkg.sv]
// shared constants and types for the ising worm update step core
`timescale 1ns / 1ps

package iwu_pkg;

  localparam int unsigned THR_W      = 16;
  localparam int unsigned START_W    = 6;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned PAIRS_W    = 3;
  localparam int unsigned END_W      = 2;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned NUM_ENDS   = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_THRESHOLD = 3'd0;
  localparam cfg_idx_t CFG_START_AX  = 3'd1;
  localparam cfg_idx_t CFG_START_AY  = 3'd2;
  localparam cfg_idx_t CFG_START_BX  = 3'd3;
  localparam cfg_idx_t CFG_START_BY  = 3'd4;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd27000;

  // move directions
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

  // coincidence counts that feed the four-point total
  localparam logic [PAIRS_W-1:0] PAIRS_TWO = 3'd2;
  localparam logic [PAIRS_W-1:0] PAIRS_ALL = 3'd6;
  localparam logic [PAIRS_W-1:0] FOUR_INC_TWO = 3'd1;
  localparam logic [PAIRS_W-1:0] FOUR_INC_ALL = 3'd6;

  // one access to the link store
  typedef struct packed {
    logic rd;
    logic wr;
    logic wdata;
  } link_req_t;

endpackage

[src/iwu_link_store.sv]
// link bit memory with a clearing pass after reset
`timescale 1ns / 1ps

module iwu_link_store #(
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  iwu_pkg::link_req_t       req_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic                     rd_data_o,
  output logic                     busy_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic          rd_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 1'b0;
    end else if (req_i.wr) begin
      mem[addr_i] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rd_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_busy_q;

endmodule

[src/ising_worm_update_step_core.sv]
// top level of the ising worm update step core
`timescale 1ns / 1ps

// One worm move per transfer on a periodic LATTICE_SIDE x LATTICE_SIDE lattice
// of link bits (two per site: horizontal to x+1, vertical to y+1). In the
// cycle an item is accepted the crossed link is read from the link memory;
// when it completes stage b the read data decides whether the move is kept,
// the link is written back, the end positions and the saturating totals are
// updated and the result is loaded into the output register. The next item
// is taken in the cycle after that, so the write always lands before the
// following read and the end positions are current. While a result waits in
// the output register the next item is still accepted and its link is read;
// it completes once the result is taken. After reset the link memory is
// cleared one entry a cycle, all 2*LATTICE_SIDE*LATTICE_SIDE entries (8192
// at the default side), with in_stall_o high; configuration writes are taken
// at all times and must only be made while the block is idle. The low START_W
// bits of a start coordinate are reduced modulo LATTICE_SIDE when written.
module ising_worm_update_step_core #(
  parameter int unsigned LATTICE_SIDE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [iwu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [iwu_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [iwu_pkg::END_W-1:0]       end_select_i,
  input  logic [iwu_pkg::DIR_W-1:0]       direction_i,
  input  logic [iwu_pkg::THR_W-1:0]       random_fraction_i,
  input  logic                            place_ends_i,
  input  logic                            clear_totals_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic                            crossed_link_occupied_o,
  output logic [iwu_pkg::PAIRS_W-1:0]     coincident_pairs_o,
  output logic [iwu_pkg::TOTAL_W-1:0]     pair_total_o,
  output logic [iwu_pkg::TOTAL_W-1:0]     four_point_total_o
);

  localparam int unsigned CW         = $clog2(LATTICE_SIDE);
  localparam int unsigned LINK_DEPTH = 2 * LATTICE_SIDE * LATTICE_SIDE;
  localparam int unsigned AW         = $clog2(LINK_DEPTH);
  localparam int unsigned START_N    = 2 ** iwu_pkg::START_W;
  localparam int unsigned TW         = iwu_pkg::TOTAL_W;

  // start coordinate reduction table (constant)
  logic [CW-1:0] mod_tab [START_N];
  for (genvar g = 0; g < START_N; g++) begin : g_mod
    assign mod_tab[g] = CW'(g % LATTICE_SIDE);
  end

  // configuration registers
  logic [iwu_pkg::THR_W-1:0] thr_q;
  logic [CW-1:0] start_ax_q, start_ay_q, start_bx_q, start_by_q;
  logic [CW-1:0] cfg_mod;

  assign cfg_mod = mod_tab[cfg_wdata_i[iwu_pkg::START_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= iwu_pkg::THRESHOLD_RESET;
      start_ax_q <= '0;
      start_ay_q <= '0;
      start_bx_q <= '0;
      start_by_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iwu_pkg::CFG_THRESHOLD: thr_q      <= cfg_wdata_i[iwu_pkg::THR_W-1:0];
        iwu_pkg::CFG_START_AX:  start_ax_q <= cfg_mod;
        iwu_pkg::CFG_START_AY:  start_ay_q <= cfg_mod;
        iwu_pkg::CFG_START_BX:  start_bx_q <= cfg_mod;
        iwu_pkg::CFG_START_BY:  start_by_q <= cfg_mod;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // end positions, flops
  logic [CW-1:0] pos_x_q [iwu_pkg::NUM_ENDS];
  logic [CW-1:0] pos_y_q [iwu_pkg::NUM_ENDS];

  // pipeline control
  logic clr_busy;
  logic in_fire;
  logic b_valid_q;
  logic b_fire;
  logic out_valid_q;

  assign in_stall_o = clr_busy | b_valid_q;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign b_fire     = b_valid_q & (~out_valid_q | ~out_stall_i);

  // stage a: pick up the old position (after optional placement)
  logic [CW-1:0] ox, oy, nx, ny, lx, ly;
  logic          lv;
  logic [AW-2:0] site_idx;
  logic [AW-1:0] a_addr;

  always_comb begin
    if (place_ends_i) begin
      ox = end_select_i[1] ? start_bx_q : start_ax_q;
      oy = end_select_i[1] ? start_by_q : start_ay_q;
    end else begin
      ox = pos_x_q[end_select_i];
      oy = pos_y_q[end_select_i];
    end
    nx = ox;
    ny = oy;
    lx = ox;
    ly = oy;
    lv = 1'b0;
    unique case (direction_i)
      iwu_pkg::DIR_LEFT: begin
        nx = (ox == '0) ? CW'(LATTICE_SIDE - 1) : ox - CW'(1);
        lx = nx;
      end
      iwu_pkg::DIR_RIGHT: begin
        nx = (ox == CW'(LATTICE_SIDE - 1)) ? '0 : ox + CW'(1);
      end
      iwu_pkg::DIR_DOWN: begin
        ny = (oy == '0) ? CW'(LATTICE_SIDE - 1) : oy - CW'(1);
        ly = ny;
        lv = 1'b1;
      end
      default: begin  // up
        ny = (oy == CW'(LATTICE_SIDE - 1)) ? '0 : oy + CW'(1);
        lv = 1'b1;
      end
    endcase
    site_idx = (AW-1)'(ly) * (AW-1)'(LATTICE_SIDE) + (AW-1)'(lx);
    a_addr   = {site_idx, lv};
  end

  // stage b registers
  logic [iwu_pkg::END_W-1:0] b_sel_q;
  logic [CW-1:0]             b_nx_q, b_ny_q;
  logic [AW-1:0]             b_addr_q;
  logic [iwu_pkg::THR_W-1:0] b_rnd_q;
  logic                      b_clear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_fire) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_sel_q   <= end_select_i;
      b_nx_q    <= nx;
      b_ny_q    <= ny;
      b_addr_q  <= a_addr;
      b_rnd_q   <= random_fraction_i;
      b_clear_q <= clear_totals_i;
    end
  end

  // link memory: read at accept, write back when stage b completes
  iwu_pkg::link_req_t mem_req;
  logic [AW-1:0]      mem_addr;
  logic               rd_bit;
  logic               occ;
  logic               keep;

  assign occ  = ~rd_bit;
  assign keep = ~(occ & (thr_q < b_rnd_q));

  always_comb begin
    mem_req.rd    = in_fire;
    mem_req.wr    = b_fire & keep;
    mem_req.wdata = occ;
    mem_addr      = b_fire ? b_addr_q : a_addr;
  end

  iwu_link_store #(
    .DEPTH (LINK_DEPTH)
  ) u_link_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .addr_i    (mem_addr),
    .rd_data_o (rd_bit),
    .busy_o    (clr_busy)
  );

  // stage b: positions after the move and coincidence count
  logic [CW-1:0]               px_n [iwu_pkg::NUM_ENDS];
  logic [CW-1:0]               py_n [iwu_pkg::NUM_ENDS];
  logic [iwu_pkg::PAIRS_W-1:0] pairs;

  always_comb begin
    for (int i = 0; i < iwu_pkg::NUM_ENDS; i++) begin
      if (keep && (b_sel_q == iwu_pkg::END_W'(i))) begin
        px_n[i] = b_nx_q;
        py_n[i] = b_ny_q;
      end else begin
        px_n[i] = pos_x_q[i];
        py_n[i] = pos_y_q[i];
      end
    end
    pairs = '0;
    for (int i = 0; i < iwu_pkg::NUM_ENDS - 1; i++) begin
      for (int j = i + 1; j < iwu_pkg::NUM_ENDS; j++) begin
        if (px_n[i] == px_n[j] && py_n[i] == py_n[j]) begin
          pairs = pairs + iwu_pkg::PAIRS_W'(1);
        end
      end
    end
  end

  // position update: placement at accept, move at completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < iwu_pkg::NUM_ENDS; i++) begin
        pos_x_q[i] <= '0;
        pos_y_q[i] <= '0;
      end
    end else if (in_fire && place_ends_i) begin
      pos_x_q[0] <= start_ax_q;
      pos_y_q[0] <= start_ay_q;
      pos_x_q[1] <= start_ax_q;
      pos_y_q[1] <= start_ay_q;
      pos_x_q[2] <= start_bx_q;
      pos_y_q[2] <= start_by_q;
      pos_x_q[3] <= start_bx_q;
      pos_y_q[3] <= start_by_q;
    end else if (b_fire && keep) begin
      pos_x_q[b_sel_q] <= b_nx_q;
      pos_y_q[b_sel_q] <= b_ny_q;
    end
  end

  // saturating totals
  logic [TW-1:0]               pair_sum_q, four_sum_q;
  logic [TW-1:0]               pair_base, four_base, pair_sum_d, four_sum_d;
  logic [iwu_pkg::PAIRS_W-1:0] four_inc;
  logic [TW:0]                 pair_add, four_add;

  always_comb begin
    pair_base = b_clear_q ? '0 : pair_sum_q;
    four_base = b_clear_q ? '0 : four_sum_q;
    priority if (pairs == iwu_pkg::PAIRS_ALL) begin
      four_inc = iwu_pkg::FOUR_INC_ALL;
    end else if (pairs == iwu_pkg::PAIRS_TWO) begin
      four_inc = iwu_pkg::FOUR_INC_TWO;
    end else begin
      four_inc = '0;
    end
    pair_add   = {1'b0, pair_base} + (TW+1)'(pairs);
    four_add   = {1'b0, four_base} + (TW+1)'(four_inc);
    pair_sum_d = pair_add[TW] ? '1 : pair_add[TW-1:0];
    four_sum_d = four_add[TW] ? '1 : four_add[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_sum_q  <= '0;
      four_sum_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (b_fire) begin
      pair_sum_q  <= pair_sum_d;
      four_sum_q  <= four_sum_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload; totals change only when a new result loads
  logic                        acc_q, occ_q;
  logic [iwu_pkg::PAIRS_W-1:0] pairs_q;

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      acc_q   <= keep;
      occ_q   <= occ;
      pairs_q <= pairs;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign accepted_o              = acc_q;
  assign crossed_link_occupied_o = occ_q;
  assign coincident_pairs_o      = pairs_q;
  assign pair_total_o            = pair_sum_q;
  assign four_point_total_o      = four_sum_q;

endmodule

[test/tb_ising_worm_update_step_core.sv]
// self-checking testbench for the ising worm update step core
`timescale 1ns / 1ps

module tb_ising_worm_update_step_core;

  localparam int unsigned SIDE        = 64;
  localparam int unsigned LINK_SLOTS  = 2 * SIDE * SIDE;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 18;

  typedef struct packed {
    logic                          accepted;
    logic                          occupied;
    logic [iwu_pkg::PAIRS_W-1:0]   pairs;
    logic [iwu_pkg::TOTAL_W-1:0]   pair_total;
    logic [iwu_pkg::TOTAL_W-1:0]   four_total;
  } move_result_t;

  logic                           clk_i             = 1'b0;
  logic                           rst_ni            = 1'b0;
  logic                           cfg_we_i          = 1'b0;
  logic [iwu_pkg::CFG_IDX_W-1:0]  cfg_idx_i         = '0;
  logic [iwu_pkg::CFG_DATA_W-1:0] cfg_wdata_i       = '0;
  logic                           in_valid_i        = 1'b0;
  logic                           in_stall_o;
  logic [iwu_pkg::END_W-1:0]      end_select_i      = '0;
  logic [iwu_pkg::DIR_W-1:0]      direction_i       = '0;
  logic [iwu_pkg::THR_W-1:0]      random_fraction_i = '0;
  logic                           place_ends_i      = 1'b0;
  logic                           clear_totals_i    = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i       = 1'b0;
  logic                           accepted_o;
  logic                           crossed_link_occupied_o;
  logic [iwu_pkg::PAIRS_W-1:0]    coincident_pairs_o;
  logic [iwu_pkg::TOTAL_W-1:0]    pair_total_o;
  logic [iwu_pkg::TOTAL_W-1:0]    four_point_total_o;

  ising_worm_update_step_core #(
    .LATTICE_SIDE(SIDE)
  ) u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .end_select_i           (end_select_i),
    .direction_i            (direction_i),
    .random_fraction_i      (random_fraction_i),
    .place_ends_i           (place_ends_i),
    .clear_totals_i         (clear_totals_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .accepted_o             (accepted_o),
    .crossed_link_occupied_o(crossed_link_occupied_o),
    .coincident_pairs_o     (coincident_pairs_o),
    .pair_total_o           (pair_total_o),
    .four_point_total_o     (four_point_total_o)
  );

  always #1 clk_i = ~clk_i;

  // lattice model state and register copies
  bit             link_map [LINK_SLOTS];
  int unsigned    end_x [iwu_pkg::NUM_ENDS];
  int unsigned    end_y [iwu_pkg::NUM_ENDS];
  logic [31:0]    pair_sum;
  logic [31:0]    four_sum;
  logic [15:0]    thr_reg  = iwu_pkg::THRESHOLD_RESET;
  int unsigned    start_ax = 0;
  int unsigned    start_ay = 0;
  int unsigned    start_bx = 0;
  int unsigned    start_by = 0;

  move_result_t   pending_moves [$];

  bit             tx_idle_on    = 1'b1;
  bit             rx_idle_on    = 1'b1;
  int unsigned    rx_hold_cycles = 0;
  int unsigned    cycle_count   = 0;
  int unsigned    err_count     = 0;
  int unsigned    moves_sent    = 0;
  int unsigned    results_seen  = 0;
  int unsigned    kept_count    = 0;
  int unsigned    multi_pairs   = 0;
  int unsigned    reg_writes    = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int unsigned link_slot(int unsigned x, int unsigned y, bit vert);
    return ((y % SIDE) * SIDE + (x % SIDE)) * 2 + vert;
  endfunction

  // one worm move on the lattice copy; returns the result the core should give
  function automatic move_result_t predict_move(logic [iwu_pkg::END_W-1:0] sel,
                                                logic [iwu_pkg::DIR_W-1:0] dir,
                                                logic [iwu_pkg::THR_W-1:0] frac,
                                                logic place, logic clr);
    int unsigned  ox, oy, nx, ny, li, n;
    logic         flipped, keep;
    move_result_t r;
    if (place) begin
      for (int e = 0; e < iwu_pkg::NUM_ENDS; e++) begin
        end_x[e] = ((e < 2) ? start_ax : start_bx) % SIDE;
        end_y[e] = ((e < 2) ? start_ay : start_by) % SIDE;
      end
    end
    if (clr) begin
      pair_sum = '0;
      four_sum = '0;
    end
    ox = end_x[sel];
    oy = end_y[sel];
    nx = ox;
    ny = oy;
    // left and down cross the link owned by the new site
    case (dir)
      iwu_pkg::DIR_LEFT: begin
        nx = (ox + SIDE - 1) % SIDE;
        li = link_slot(nx, oy, 1'b0);
      end
      iwu_pkg::DIR_RIGHT: begin
        nx = (ox + 1) % SIDE;
        li = link_slot(ox, oy, 1'b0);
      end
      iwu_pkg::DIR_DOWN: begin
        ny = (oy + SIDE - 1) % SIDE;
        li = link_slot(ox, ny, 1'b1);
      end
      default: begin
        ny = (oy + 1) % SIDE;
        li = link_slot(ox, oy, 1'b1);
      end
    endcase
    flipped = ~link_map[li];
    keep    = !(flipped && (thr_reg < frac));
    if (keep) begin
      link_map[li] = flipped;
      end_x[sel]   = nx;
      end_y[sel]   = ny;
    end
    n = 0;
    for (int i = 0; i < iwu_pkg::NUM_ENDS - 1; i++)
      for (int j = i + 1; j < iwu_pkg::NUM_ENDS; j++)
        if (end_x[i] == end_x[j] && end_y[i] == end_y[j]) n++;
    pair_sum = sat_add(pair_sum, n);
    if (n == iwu_pkg::PAIRS_TWO) four_sum = sat_add(four_sum, 32'(iwu_pkg::FOUR_INC_TWO));
    if (n == iwu_pkg::PAIRS_ALL) four_sum = sat_add(four_sum, 32'(iwu_pkg::FOUR_INC_ALL));
    r.accepted   = keep;
    r.occupied   = flipped;
    r.pairs      = n[iwu_pkg::PAIRS_W-1:0];
    r.pair_total = pair_sum;
    r.four_total = four_sum;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d (result %0d)",
                                name, got, want, results_seen));
  endtask

  // sender: random gaps, valid held until the transfer completes
  task automatic send_move(logic [iwu_pkg::END_W-1:0] sel, logic [iwu_pkg::DIR_W-1:0] dir,
                           logic [iwu_pkg::THR_W-1:0] frac, logic place, logic clr);
    @(negedge clk_i);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    end_select_i      <= sel;
    direction_i       <= dir;
    random_fraction_i <= frac;
    place_ends_i      <= place;
    clear_totals_i    <= clr;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    pending_moves.insert(pending_moves.size(), predict_move(sel, dir, frac, place, clr));
    moves_sent++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(iwu_pkg::cfg_idx_t idx, logic [iwu_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      iwu_pkg::CFG_THRESHOLD: thr_reg  = data[iwu_pkg::THR_W-1:0];
      iwu_pkg::CFG_START_AX:  start_ax = data[iwu_pkg::START_W-1:0] % SIDE;
      iwu_pkg::CFG_START_AY:  start_ay = data[iwu_pkg::START_W-1:0] % SIDE;
      iwu_pkg::CFG_START_BX:  start_bx = data[iwu_pkg::START_W-1:0] % SIDE;
      iwu_pkg::CFG_START_BY:  start_by = data[iwu_pkg::START_W-1:0] % SIDE;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (rx_hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      out_stall_i <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    move_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_moves.size() == 0) begin
        report_mismatch("result transfer with no move outstanding");
      end else begin
        want = pending_moves.pop_front();
        check_field("accepted", 32'(accepted_o), 32'(want.accepted));
        check_field("crossed_link_occupied", 32'(crossed_link_occupied_o),
                    32'(want.occupied));
        check_field("coincident_pairs", 32'(coincident_pairs_o), 32'(want.pairs));
        check_field("pair_total", pair_total_o, want.pair_total);
        check_field("four_point_total", four_point_total_o, want.four_total);
        if (want.accepted) kept_count++;
        if (want.pairs >= iwu_pkg::PAIRS_TWO) multi_pairs++;
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d moves outstanding",
               cycle_count, pending_moves.size());
      $display("FAIL ising_worm_update_step_core");
      $finish;
    end
  end

  // all ends at the origin: crossings, wraparound, equal threshold
  task automatic test_directed_moves();
    send_move(2'd0, iwu_pkg::DIR_RIGHT, 16'hFFFF, 1'b1, 1'b1);
    send_move(2'd0, iwu_pkg::DIR_RIGHT, 16'h0000, 1'b0, 1'b0);
    send_move(2'd0, iwu_pkg::DIR_LEFT, 16'hFFFF, 1'b0, 1'b0);  // empties the same link
    send_move(2'd1, iwu_pkg::DIR_LEFT, 16'h0000, 1'b0, 1'b0);  // wraps to the last column
    send_move(2'd2, iwu_pkg::DIR_DOWN, iwu_pkg::THRESHOLD_RESET, 1'b0, 1'b0);
    send_move(2'd3, iwu_pkg::DIR_UP, iwu_pkg::THRESHOLD_RESET + 16'd1, 1'b0, 1'b0);
    send_move(2'd3, iwu_pkg::DIR_UP, iwu_pkg::THRESHOLD_RESET, 1'b0, 1'b0);
    send_move(2'd3, iwu_pkg::DIR_DOWN, 16'hFFFF, 1'b0, 1'b0);
    send_move(2'd2, iwu_pkg::DIR_UP, 16'h0000, 1'b0, 1'b0);
    send_move(2'd1, iwu_pkg::DIR_RIGHT, 16'h0000, 1'b0, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    settle_block();
    write_reg(iwu_pkg::CFG_THRESHOLD, 16'h0000);
    send_move(2'd0, iwu_pkg::DIR_RIGHT, 16'h0000, 1'b0, 1'b0);
    send_move(2'd0, iwu_pkg::DIR_RIGHT, 16'h0001, 1'b0, 1'b0);
    settle_block();
    write_reg(iwu_pkg::CFG_THRESHOLD, 16'hFFFF);
    send_move(2'd0, iwu_pkg::DIR_RIGHT, 16'hFFFF, 1'b0, 1'b0);
  endtask

  // start sites at the lattice edge, upper data bits set, unused indexes
  task automatic test_start_registers();
    settle_block();
    write_reg(iwu_pkg::CFG_START_AX, 16'hFFFF);
    write_reg(iwu_pkg::CFG_START_AY, 16'h003F);
    write_reg(iwu_pkg::CFG_START_BX, 16'h0040);
    write_reg(iwu_pkg::CFG_START_BY, 16'hFFFF);
    for (int k = iwu_pkg::CFG_START_BY + 1; k < (1 << iwu_pkg::CFG_IDX_W); k++)
      write_reg(iwu_pkg::cfg_idx_t'(k), 16'h0000);
    send_move(2'd0, iwu_pkg::DIR_RIGHT, 16'h0000, 1'b1, 1'b1);
    send_move(2'd1, iwu_pkg::DIR_UP, 16'hFFFF, 1'b0, 1'b0);
    send_move(2'd1, iwu_pkg::DIR_DOWN, 16'hFFFF, 1'b0, 1'b0);
    send_move(2'd1, iwu_pkg::DIR_RIGHT, 16'h8000, 1'b0, 1'b0);
    send_move(2'd0, iwu_pkg::DIR_LEFT, 16'h0000, 1'b1, 1'b0);
    send_move(2'd1, iwu_pkg::DIR_LEFT, 16'h0000, 1'b0, 1'b0);
    send_move(2'd2, iwu_pkg::DIR_DOWN, 16'h0000, 1'b0, 1'b0);
    send_move(2'd3, iwu_pkg::DIR_UP, 16'h0000, 1'b0, 1'b0);
    send_move(2'd0, iwu_pkg::DIR_RIGHT, 16'h0000, 1'b0, 1'b0);
  endtask

  // random walks from nearby start sites so ends keep meeting
  task automatic test_random_walks(int unsigned n_moves, logic [15:0] thr, bit idle_on);
    logic [5:0]  ax, ay;
    logic [15:0] frac;
    settle_block();
    ax = $urandom_range(63);
    ay = $urandom_range(63);
    write_reg(iwu_pkg::CFG_THRESHOLD, thr);
    write_reg(iwu_pkg::CFG_START_AX, {10'($urandom_range(1023)), ax});
    write_reg(iwu_pkg::CFG_START_AY, {10'($urandom_range(1023)), ay});
    write_reg(iwu_pkg::CFG_START_BX, {10'($urandom_range(1023)), 6'(ax + $urandom_range(2))});
    write_reg(iwu_pkg::CFG_START_BY, {10'($urandom_range(1023)), 6'(ay - $urandom_range(2))});
    tx_idle_on = idle_on;
    rx_idle_on = idle_on;
    send_move(2'($urandom_range(3)), 2'($urandom_range(3)), 16'($urandom), 1'b1, 1'b1);
    repeat (n_moves - 1) begin
      case ($urandom_range(9))
        6:       frac = thr;
        7:       frac = thr + 16'd1;
        8:       frac = thr - 16'd1;
        9:       frac = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: frac = 16'($urandom);
      endcase
      send_move(2'($urandom_range(3)), 2'($urandom_range(3)), frac,
                $urandom_range(15) == 0, $urandom_range(39) == 0);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering moves
  task automatic test_output_backpressure();
    settle_block();
    tx_idle_on     = 1'b0;
    rx_hold_cycles = 400;
    repeat (16)
      send_move(2'($urandom_range(3)), 2'($urandom_range(3)), 16'($urandom), 1'b0, 1'b0);
    tx_idle_on = 1'b1;
  endtask

  initial begin
    for (int e = 0; e < iwu_pkg::NUM_ENDS; e++) begin
      end_x[e] = 0;
      end_y[e] = 0;
    end
    pair_sum = '0;
    four_sum = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_moves();
    test_threshold_extremes();
    test_start_registers();
    test_random_walks(220, 16'($urandom), 1'b1);
    test_random_walks(220, 16'h0000, 1'b1);
    test_random_walks(220, 16'd27000, 1'b0);
    test_random_walks(220, 16'hFFFF, 1'b1);
    test_random_walks(220, 16'h8000, 1'b1);
    test_output_backpressure();

    settle_block();
    repeat (10) @(posedge clk_i);
    $display("covered %0d moves (%0d kept) and %0d results checked over %0d register writes",
             moves_sent, kept_count, results_seen, reg_writes);
    $display("%0d results had two or more coinciding end pairs", multi_pairs);
    if (err_count == 0) begin
      $display("PASS ising_worm_update_step_core");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL ising_worm_update_step_core");
    end
    $finish;
  end

endmodule
